// ===== rtl/mbe_pkg.sv =====
`default_nettype none

package mbe_pkg;

  localparam int Q_FRAC = 28;
  localparam int X_PIXELS_DEFAULT = 800;
  localparam int Y_PIXELS_DEFAULT = 600;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_REAL = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ORIGIN_IMAG = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_REAL = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STEP_IMAG = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS = 3'd4;

  localparam logic signed [31:0] ORIGIN_REAL_RESET = -32'sd536870912;
  localparam logic signed [31:0] ORIGIN_IMAG_RESET = -32'sd268435456;
  localparam logic [30:0] STEP_REAL_RESET = 31'd1006633;
  localparam logic [30:0] STEP_IMAG_RESET = 31'd894785;
  localparam logic [15:0] MAX_ITERATIONS_RESET = 16'd100;

  // |z|^2 >= 4 in Q8.56.
  localparam logic [63:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] cr;
    logic signed [31:0] ci;
  } coord_t;

  function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
    logic signed [31:0] r;
    if (v[47:31] == {17{v[47]}}) begin
      r = v[31:0];
    end else if (v[47]) begin
      r = 32'sh8000_0000;
    end else begin
      r = 32'sh7fff_ffff;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mbe_fifo.sv =====
`default_nettype none

module mbe_fifo
  import mbe_pkg::*;
#(
  parameter int WIDTH = 64,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rd_data,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign empty = (count == '0);
  assign full = (count == CNT_W'(DEPTH));
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbe_front.sv =====
`default_nettype none

module mbe_front
  import mbe_pkg::*;
#(
  parameter int X_PIXELS = X_PIXELS_DEFAULT,
  parameter int Y_PIXELS = Y_PIXELS_DEFAULT
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               accept,
  input  wire logic        [9:0]  pixel_x,
  input  wire logic        [9:0]  pixel_y,
  input  wire logic signed [31:0] origin_real,
  input  wire logic signed [31:0] origin_imag,
  input  wire logic        [30:0] step_real,
  input  wire logic        [30:0] step_imag,
  output logic                    active,
  output logic                    push,
  output coord_t                  coord
);

  localparam logic [31:0] X_LAST = 32'(X_PIXELS - 1);
  localparam logic [31:0] Y_LAST = 32'(Y_PIXELS - 1);

  logic        v0;
  logic        v1;
  logic [9:0]  px;
  logic [9:0]  py;
  logic [40:0] prod_x;
  logic [40:0] prod_y;
  logic [9:0]  px_next;
  logic [9:0]  py_next;

  // Columns and rows past the view edge are pinned to the last one.
  assign px_next = ({22'd0, pixel_x} > X_LAST) ? X_LAST[9:0] : pixel_x;
  assign py_next = ({22'd0, pixel_y} > Y_LAST) ? Y_LAST[9:0] : pixel_y;

  assign active = v0 | v1;
  assign push = v1;
  assign coord.cr = sat32({{16{origin_real[31]}}, origin_real} + {7'd0, prod_x});
  assign coord.ci = sat32({{16{origin_imag[31]}}, origin_imag} + {7'd0, prod_y});

  always_ff @(posedge clk) begin
    if (accept) begin
      px <= px_next;
      py <= py_next;
    end
    if (v0) begin
      prod_x <= {31'd0, px} * {10'd0, step_real};
      prod_y <= {31'd0, py} * {10'd0, step_imag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      v0 <= accept;
      v1 <= v0;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mbe_core.sv =====
`default_nettype none

module mbe_core
  import mbe_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        empty,
  input  wire coord_t      coord,
  input  wire logic [15:0] max_iterations,
  output logic             pop,
  output logic             done,
  output logic      [15:0] iteration_count,
  output logic             inside_set
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPD,
    S_MUL,
    S_CHK
  } state_t;

  state_t             state;
  logic signed [31:0] cr;
  logic signed [31:0] ci;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic signed [63:0] rr;
  logic signed [63:0] ii;
  logic signed [63:0] ri;
  logic        [15:0] cnt;

  logic signed [63:0] diff;
  logic signed [63:0] diff_sh;
  logic signed [63:0] ri_sh;
  logic signed [31:0] zr_next;
  logic signed [31:0] zi_next;
  logic        [63:0] mag;
  logic        [16:0] cnt_inc;

  assign pop = (state == S_IDLE) && !empty;

  assign diff = rr - ii;
  assign diff_sh = diff >>> Q_FRAC;
  assign ri_sh = ri >>> (Q_FRAC - 1);
  assign zr_next = sat32(diff_sh[47:0] + {{16{cr[31]}}, cr});
  assign zi_next = sat32(ri_sh[47:0] + {{16{ci[31]}}, ci});
  assign mag = $unsigned(rr) + $unsigned(ii);
  assign cnt_inc = {1'b0, cnt} + 17'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!empty) begin
            cr <= coord.cr;
            ci <= coord.ci;
            rr <= '0;
            ii <= '0;
            ri <= '0;
            cnt <= '0;
            if (max_iterations == '0) begin
              done <= 1'b1;
              iteration_count <= '0;
              inside_set <= 1'b1;
            end else begin
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          zr <= zr_next;
          zi <= zi_next;
          state <= S_MUL;
        end
        S_MUL: begin
          rr <= zr * zr;
          ii <= zi * zi;
          ri <= zr * zi;
          state <= S_CHK;
        end
        S_CHK: begin
          if (mag >= ESCAPE_LIMIT) begin
            done <= 1'b1;
            iteration_count <= cnt;
            inside_set <= 1'b0;
            state <= S_IDLE;
          end else if (cnt_inc == {1'b0, max_iterations}) begin
            done <= 1'b1;
            iteration_count <= max_iterations;
            inside_set <= 1'b1;
            state <= S_IDLE;
          end else begin
            cnt <= cnt_inc[15:0];
            zr <= zr_next;
            zi <= zi_next;
            state <= S_MUL;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/mandelbrot_escape_time_top.sv =====
// Steps: the front registers the pixel, then its products, to form c; the iterator pops c,
// loads z, then multiplies and checks once per iteration until an escape or max_iterations,
// or raises done straight from idle when max_iterations is zero. The iteration loop is shared;
// the front takes no new pixel while it is busy or the queue is full, and a two-beat queue
// lets the next coordinate be formed meanwhile.
// Reset is synchronous and restores the default view; results cannot be stalled.
`default_nettype none

module mandelbrot_escape_time_top
  import mbe_pkg::*;
#(
  parameter int X_PIXELS = X_PIXELS_DEFAULT,
  parameter int Y_PIXELS = Y_PIXELS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [9:0]             pixel_x,
  input  wire logic [9:0]             pixel_y,
  output logic                        done,
  output logic [15:0]                 iteration_count,
  output logic                        inside_set,
  input  wire logic                   cfg_write,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic signed [31:0] origin_real;
  logic signed [31:0] origin_imag;
  logic        [30:0] step_real;
  logic        [30:0] step_imag;
  logic        [15:0] max_iterations;

  logic   front_active;
  logic   push;
  coord_t push_coord;
  logic   pop;
  coord_t pop_coord;
  logic   empty;
  logic   full;
  logic   accept;

  assign busy = front_active | full;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_real <= ORIGIN_REAL_RESET;
      origin_imag <= ORIGIN_IMAG_RESET;
      step_real <= STEP_REAL_RESET;
      step_imag <= STEP_IMAG_RESET;
      max_iterations <= MAX_ITERATIONS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ORIGIN_REAL:    origin_real <= cfg_data;
        REG_ORIGIN_IMAG:    origin_imag <= cfg_data;
        REG_STEP_REAL:      step_real <= cfg_data[30:0];
        REG_STEP_IMAG:      step_imag <= cfg_data[30:0];
        REG_MAX_ITERATIONS: max_iterations <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  mbe_front #(
    .X_PIXELS(X_PIXELS),
    .Y_PIXELS(Y_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .origin_real(origin_real),
    .origin_imag(origin_imag),
    .step_real  (step_real),
    .step_imag  (step_imag),
    .active     (front_active),
    .push       (push),
    .coord      (push_coord)
  );

  mbe_fifo #(
    .WIDTH($bits(coord_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(push_coord),
    .pop    (pop),
    .rd_data(pop_coord),
    .empty  (empty),
    .full   (full)
  );

  mbe_core u_core (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .coord          (pop_coord),
    .max_iterations (max_iterations),
    .pop            (pop),
    .done           (done),
    .iteration_count(iteration_count),
    .inside_set     (inside_set)
  );

endmodule

`default_nettype wire
